@@ hdl/pal_pkg.sv @@
package pal_pkg;

  // Field widths fixed by the request and result formats.
  localparam int DATA_W       = 32;
  localparam int POS_W        = 4;
  localparam int CNT_W        = 5;
  localparam int TYPE_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;

  // Number of positions a request can address.
  localparam int POS_SPAN = 2 ** POS_W;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT   = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_RETRIEVE = 3'd2,
    REQ_REPLACE  = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every slot cell in the row.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              rep;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ hdl/pal_req_if.sv @@
interface pal_req_if;
  import pal_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [TYPE_W-1:0]          req_type;
  logic [POS_W-1:0]           position;
  logic signed [DATA_W-1:0]   value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input value,
                  output ready);
endinterface

@@ hdl/pal_rsp_if.sv @@
interface pal_rsp_if;
  import pal_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [DATA_W-1:0]   read_value;
  logic [CNT_W-1:0]           entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
endinterface

@@ hdl/pal_cell.sv @@
module pal_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  pal_pkg::cell_cmd_t        cmd,
  input  logic [pal_pkg::DATA_W-1:0] left_data,
  input  logic [pal_pkg::DATA_W-1:0] right_data,
  output logic [pal_pkg::DATA_W-1:0] data_o
);
  import pal_pkg::*;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_LEFT,
    ACT_RIGHT
  } cell_act_t;

  // Where this cell sits relative to the addressed position.
  localparam bit               BEYOND = (IDX >= POS_SPAN);
  localparam logic [POS_W-1:0] IDX_LO = POS_W'(IDX % POS_SPAN);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              at_pos;
  logic              past_pos;
  cell_act_t         act;

  assign at_pos   = !BEYOND && (cmd.pos == IDX_LO);
  assign past_pos = BEYOND || (IDX_LO > cmd.pos);

  // Insert opens a gap at the position, remove closes it from above, replace loads it.
  always_comb begin
    act = ACT_HOLD;
    if (cmd.ins) begin
      if (at_pos) begin
        act = ACT_LOAD;
      end else if (past_pos) begin
        act = ACT_LEFT;
      end
    end else if (cmd.rem) begin
      if (at_pos || past_pos) begin
        act = ACT_RIGHT;
      end
    end else if (cmd.rep) begin
      if (at_pos) begin
        act = ACT_LOAD;
      end
    end
  end

  always_comb begin
    unique case (act)
      ACT_LOAD:  data_nxt = cmd.value;
      ACT_LEFT:  data_nxt = left_data;
      ACT_RIGHT: data_nxt = right_data;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

@@ hdl/positional_array_list_unit.sv @@
// Ordered list of up to CAPACITY signed 32-bit entries kept in a row of slot
// cells. Requests are insert, remove, retrieve, replace and clear; each gives
// exactly one result with a status, a value and the entry count after the
// request. Each result appears in the output register in the cycle after its
// request is accepted, and a new request is accepted in every cycle while the
// output register is empty or being taken. That rate is set by the cell row,
// where every moving cell loads from its left or right neighbor in the same
// cycle, so an insert or remove moves all entries at once. Positions 0 to 15
// can be addressed. Slots hold no reset value; clear only resets the count,
// and a read returns 0 unless the request is a successful retrieve or remove.
module positional_array_list_unit #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pal_req_if.sink    in_req,
  pal_rsp_if.source  out_rsp
);
  import pal_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int RD_N = (CAPACITY < POS_SPAN) ? CAPACITY : POS_SPAN;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [DATA_W-1:0] read_value_r;
  logic [CNT_W-1:0]  entry_count_r;

  logic              accept;
  logic [CMPW-1:0]   pos_x;
  logic [CMPW-1:0]   cnt_x;
  logic              in_list;
  logic              ins_ok;
  logic              rem_ok;
  logic              rep_ok;
  status_t           status;
  logic [DATA_W-1:0] rd_sel;
  logic [DATA_W-1:0] rd_value;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] slot_q [CAPACITY];

  // A transfer is taken whenever the result register is free or draining.
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  assign pos_x   = CMPW'(in_req.position);
  assign cnt_x   = CMPW'(count_r);
  assign in_list = (pos_x < cnt_x);

  // Entry at the addressed position, only the first positions are reachable.
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (in_req.position == POS_W'(i)) begin
        rd_sel = slot_q[i];
      end
    end
  end

  // Request decode and range checks.
  always_comb begin
    status    = ST_OK;
    ins_ok    = 1'b0;
    rem_ok    = 1'b0;
    rep_ok    = 1'b0;
    rd_value  = '0;
    count_nxt = count_r;
    unique case (in_req.req_type)
      REQ_INSERT: begin
        if (count_r == CW'(CAPACITY)) begin
          status = ST_FULL;
        end else if (pos_x > cnt_x) begin
          status = ST_RANGE;
        end else begin
          ins_ok    = 1'b1;
          count_nxt = CW'(count_r + 1'b1);
        end
      end
      REQ_REMOVE: begin
        if (!in_list) begin
          status = ST_RANGE;
        end else begin
          rem_ok    = 1'b1;
          rd_value  = rd_sel;
          count_nxt = CW'(count_r - 1'b1);
        end
      end
      REQ_RETRIEVE: begin
        if (!in_list) begin
          status = ST_RANGE;
        end else begin
          rd_value = rd_sel;
        end
      end
      REQ_REPLACE: begin
        if (!in_list) begin
          status = ST_RANGE;
        end else begin
          rep_ok = 1'b1;
        end
      end
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  // Command to the cell row, active only for an accepted request.
  always_comb begin
    cmd.ins   = accept && ins_ok;
    cmd.rem   = accept && rem_ok;
    cmd.rep   = accept && rep_ok;
    cmd.pos   = in_req.position;
    cmd.value = in_req.value;
  end

  // Row of slot cells; each end takes its own edge input.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = in_req.value;
    end else begin : g_mid_l
      assign left_d = slot_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_d = slot_q[g];
    end else begin : g_mid_r
      assign right_d = slot_q[g+1];
    end

    pal_cell #(
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (slot_q[g])
    );
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status;
      read_value_r  <= rd_value;
      entry_count_r <= CNT_W'(count_nxt);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = status_r;
  assign out_rsp.read_value  = read_value_r;
  assign out_rsp.entry_count = entry_count_r;

endmodule
